>>> sv/tcp_client_connection_engine_defines.svh
// Assertion macros used by the connection engine checker.
`ifndef TCP_CLIENT_CONNECTION_ENGINE_DEFINES_SVH
`define TCP_CLIENT_CONNECTION_ENGINE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define TCE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
// Next-cycle implication checked outside reset.
`define TCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`endif

>>> sv/tce_pkg.sv
// Shared types, codes and helpers of the TCP client connection engine.
package tce_pkg;
   localparam int DEF_SLOTS    = 8;
   localparam int DEF_MAX_SEND = 512;
   localparam int RES_MAX      = 8;

   localparam logic [2:0] OP_CONNECT = 3'd0;
   localparam logic [2:0] OP_ARP     = 3'd1;
   localparam logic [2:0] OP_SEGMENT = 3'd2;
   localparam logic [2:0] OP_SEND    = 3'd3;
   localparam logic [2:0] OP_CLOSE   = 3'd4;
   localparam logic [2:0] OP_POLL    = 3'd5;
   localparam logic [2:0] OP_RSVD    = 3'd6;
   localparam logic [2:0] OP_DROP    = 3'd7;

   localparam logic [2:0] ACT_NONE = 3'd0;
   localparam logic [2:0] ACT_ARP  = 3'd1;
   localparam logic [2:0] ACT_SYN  = 3'd2;
   localparam logic [2:0] ACT_ACK  = 3'd3;
   localparam logic [2:0] ACT_DATA = 3'd4;
   localparam logic [2:0] ACT_FIN  = 3'd5;

   localparam logic [2:0] ST_CLOSED   = 3'd0;
   localparam logic [2:0] ST_SYN_SENT = 3'd1;
   localparam logic [2:0] ST_EST      = 3'd2;
   localparam logic [2:0] ST_FW1      = 3'd3;
   localparam logic [2:0] ST_FW2      = 3'd4;
   localparam logic [2:0] ST_CW       = 3'd5;
   localparam logic [2:0] ST_TW       = 3'd6;

   localparam int F_FIN = 0;
   localparam int F_SYN = 1;
   localparam int F_ACK = 4;

   localparam logic [47:0] MAC_ALL = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [2:0]  op;
      logic [2:0]  slot;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [15:0] own_port;
      logic [47:0] peer_mac;
      logic [8:0]  seg_flags;
      logic [31:0] seg_seq;
      logic [10:0] byte_count;
      logic [31:0] start_seq;
      logic        sum_ok;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [2:0]  out_slot;
      logic [31:0] tx_seq;
      logic [31:0] tx_ack;
      logic [9:0]  tx_len;
      logic [47:0] dest_mac;
      logic [31:0] dest_ip;
      logic [15:0] ip_ident;
      logic [2:0]  conn_status;
      logic        ok;
      logic        last;
   } rsp_type;

   function automatic rsp_type none_rsp(input logic [2:0] sl, input logic [2:0] st,
                                        input logic okv);
      rsp_type r;
      r = '0;
      r.out_slot    = sl;
      r.conn_status = st;
      r.ok          = okv;
      return r;
   endfunction
endpackage

>>> sv/tce_if.sv
// Valid/ready channel interface carrying one payload.
interface tce_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> sv/tcp_client_connection_engine.sv
// One transaction in flight in the back part; the slot walk
// (one slot a cycle, held while a poll result waits) sets the rate.
// Poll results leave one a cycle while the result register drains.
// Reset (synchronous, active high) closes every slot, zeroes the tables
// and sets the IP identification counter to one.
module tcp_client_connection_engine #(
   parameter int SLOTS    = tce_pkg::DEF_SLOTS,
   parameter int MAX_SEND = tce_pkg::DEF_MAX_SEND
) (
   input logic   clock,
   input logic   reset,
   tce_if.sink   req,
   tce_if.source rsp
);
   import tce_pkg::*;
   // queue between the classifying front and the executing back
   logic    f_valid, f_ready, b_valid, b_ready;
   req_type f_data, b_data;

   tce_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
   );

   tce_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   tce_back #(.SLOTS(SLOTS), .MAX_SEND(MAX_SEND)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data), .rsp(rsp)
   );
endmodule

>>> sv/tce_queue.sv
// Short FIFO between the front and back parts.
module tce_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  tce_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output tce_pkg::req_type out_data
);
   import tce_pkg::*;
   req_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end
endmodule

>>> sv/tce_front.sv
// Front part: accept a request, clean its fields and queue it.
module tce_front (
   input  logic             clock,
   input  logic             reset,
   tce_if.sink              req,
   output logic             q_valid,
   input  logic             q_ready,
   output tce_pkg::req_type q_data
);
   import tce_pkg::*;
   logic    full_ff, full_in;
   req_type hold_ff, hold_in;

   assign req.ready = !full_ff || q_ready;
   assign q_valid   = full_ff;
   assign q_data    = hold_ff;

   always_comb begin
      full_in = full_ff;
      hold_in = hold_ff;
      if (q_valid && q_ready) full_in = 1'b0;
      if (req.valid && req.ready) begin
         full_in = 1'b1;
         hold_in = req.data;
         // drop a bad-checksum segment to a plain no-match lookup
         if (req.data.op == OP_SEGMENT && !req.data.sum_ok) hold_in.op = OP_DROP;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (reset) full_ff <= 1'b0;
      else full_ff <= full_in;
   end
endmodule

>>> sv/tce_back.sv
// Back part: connection table, slot walk and result register.
module tce_back #(
   parameter int SLOTS    = tce_pkg::DEF_SLOTS,
   parameter int MAX_SEND = tce_pkg::DEF_MAX_SEND
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_ready,
   input  tce_pkg::req_type q_data,
   tce_if.source            rsp
);
   import tce_pkg::*;
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [2:0]  st_ff [SLOTS], st_in [SLOTS];
   logic [15:0] lp_ff [SLOTS], lp_in [SLOTS];
   logic [15:0] rp_ff [SLOTS], rp_in [SLOTS];
   logic [31:0] ip_ff [SLOTS], ip_in [SLOTS];
   logic [47:0] mac_ff [SLOTS], mac_in [SLOTS];
   logic [31:0] seq_ff [SLOTS], seq_in [SLOTS];
   logic [31:0] ack_ff [SLOTS], ack_in [SLOTS];
   logic [3:0]  mk_ff [SLOTS], mk_in [SLOTS];
   logic [9:0]  len_ff [SLOTS], len_in [SLOTS];
   logic [15:0] id_ff, id_in;

   logic [1:0]  fsm_ff, fsm_in;
   req_type     cur_ff, cur_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [SW-1:0] hit_ff, hit_in;
   logic        found_ff, found_in;
   logic [3:0]  nout_ff, nout_in;
   logic        seg2_ff, seg2_in;
   logic        rv_ff, rv_in;
   rsp_type     rd_ff, rd_in;

   logic [SW-1:0] ix;
   logic [SW-1:0] hs;
   logic [31:0]  sum;
   logic         emit;
   rsp_type      r;

   assign rsp.valid = rv_ff;
   assign rsp.data  = rd_ff;
   assign q_ready   = fsm_ff == S_IDLE && !rv_ff;
   assign ix = idx_ff[SW-1:0];
   assign hs = hit_ff;
   assign sum = cur_ff.seg_seq + {21'd0, cur_ff.byte_count};

   always_comb begin
      for (int k = 0; k < SLOTS; k++) begin
         st_in[k] = st_ff[k]; lp_in[k] = lp_ff[k]; rp_in[k] = rp_ff[k];
         ip_in[k] = ip_ff[k]; mac_in[k] = mac_ff[k]; seq_in[k] = seq_ff[k];
         ack_in[k] = ack_ff[k]; mk_in[k] = mk_ff[k]; len_in[k] = len_ff[k];
      end
      id_in = id_ff; fsm_in = fsm_ff; cur_in = cur_ff; idx_in = idx_ff;
      hit_in = hit_ff; found_in = found_ff; nout_in = nout_ff; seg2_in = seg2_ff;
      rv_in = rv_ff; rd_in = rd_ff;
      emit = 1'b0; r = '0;
      if (rsp.valid && rsp.ready) rv_in = 1'b0;

      unique case (fsm_ff)
         S_IDLE: begin
            if (q_valid && q_ready) begin
               cur_in = q_data; idx_in = '0; found_in = 1'b0; nout_in = '0;
               seg2_in = 1'b0; fsm_in = S_WALK;
            end
         end
         S_WALK: begin
            // one slot per cycle unless a poll result is held; a poll also ends here, lookups go on to S_EXEC
            if (cur_ff.op == OP_POLL) begin
               if (rv_ff && !rsp.ready) begin
                  fsm_in = S_WALK;
               end else if (idx_ff == CW'(SLOTS) || nout_ff == 4'(RES_MAX)) begin
                  if (nout_ff == 4'd0) begin
                     r = none_rsp(3'd0, ST_CLOSED, 1'b0); r.last = 1'b1; emit = 1'b1;
                  end
                  fsm_in = S_IDLE;
               end else begin
                  r = '0; r.out_slot = 3'(ix); r.tx_seq = seq_ff[ix];
                  r.tx_ack = ack_ff[ix]; r.dest_mac = mac_ff[ix];
                  r.dest_ip = ip_ff[ix]; r.ip_ident = id_ff;
                  r.conn_status = st_ff[ix];
                  if (mk_ff[ix][0]) begin
                     r.action = ACT_ARP; r.tx_seq = '0; r.tx_ack = '0;
                     r.ip_ident = '0; r.dest_mac = MAC_ALL; emit = 1'b1;
                     mk_in[ix][0] = 1'b0;
                  end else if (mk_ff[ix][1]) begin
                     r.action = ACT_SYN; emit = 1'b1; id_in = id_ff + 16'd1;
                     seq_in[ix] = seq_ff[ix] + 32'd1; mk_in[ix][1] = 1'b0;
                  end else if (mk_ff[ix][2] && st_ff[ix] == ST_EST) begin
                     r.action = ACT_DATA; r.tx_len = len_ff[ix]; emit = 1'b1;
                     id_in = id_ff + 16'd1;
                     seq_in[ix] = seq_ff[ix] + {22'd0, len_ff[ix]};
                     len_in[ix] = '0; mk_in[ix][2] = 1'b0;
                  end else if (mk_ff[ix][3] && st_ff[ix] == ST_EST) begin
                     r.action = ACT_FIN; r.conn_status = ST_FW1; emit = 1'b1;
                     st_in[ix] = ST_FW1; id_in = id_ff + 16'd1;
                     seq_in[ix] = seq_ff[ix] + 32'd1; mk_in[ix][3] = 1'b0;
                  end
                  // last when no later slot can emit within the cap
                  if (emit) nout_in = nout_ff + 4'd1;
                  r.last = 1'b0;
                  if (emit) begin
                     r.last = (nout_ff + 4'd1 == 4'(RES_MAX)) || (idx_ff == CW'(SLOTS - 1));
                     for (int k = 0; k < SLOTS; k++) begin
                        if (k > int'(idx_ff) && (mk_ff[k][0] || mk_ff[k][1] ||
                            ((mk_ff[k][2] || mk_ff[k][3]) && st_ff[k] == ST_EST)) &&
                            nout_ff + 4'd1 != 4'(RES_MAX)) r.last = 1'b0;
                     end
                     if (!r.last) begin
                        r.last = 1'b1;
                        for (int k = 0; k < SLOTS; k++) begin
                           if (k > int'(idx_ff) && (mk_ff[k][0] || mk_ff[k][1] ||
                               ((mk_ff[k][2] || mk_ff[k][3]) && st_ff[k] == ST_EST)))
                              r.last = 1'b0;
                        end
                     end
                  end
                  idx_in = idx_ff + CW'(1);
                  if (emit && r.last) fsm_in = S_IDLE;
               end
            end else if ((cur_ff.op == OP_ARP || cur_ff.op == OP_SEGMENT) &&
                         idx_ff != CW'(SLOTS) && !found_ff) begin
               if (cur_ff.op == OP_ARP ? (st_ff[ix] == ST_SYN_SENT &&
                                         ip_ff[ix] == cur_ff.peer_ip)
                   : (lp_ff[ix] == cur_ff.own_port && rp_ff[ix] == cur_ff.peer_port &&
                      ip_ff[ix] == cur_ff.peer_ip)) begin
                  found_in = 1'b1; hit_in = ix;
               end else begin
                  idx_in = idx_ff + CW'(1);
               end
            end else begin
               fsm_in = S_EXEC;
            end
         end
         default: begin
            // S_EXEC: apply the request; segments may need two results
            if (!(rv_ff && !rsp.ready)) begin
               fsm_in = S_IDLE; emit = 1'b1;
               r = none_rsp(3'd0, ST_CLOSED, 1'b0); r.last = 1'b1;
               case (cur_ff.op)
                  OP_CONNECT, OP_SEND, OP_CLOSE: begin
                     r.out_slot = cur_ff.slot;
                     if (int'(cur_ff.slot) < SLOTS) begin
                        if (cur_ff.op == OP_CONNECT) begin
                           st_in[cur_ff.slot[SW-1:0]] = ST_SYN_SENT;
                           ip_in[cur_ff.slot[SW-1:0]] = cur_ff.peer_ip;
                           rp_in[cur_ff.slot[SW-1:0]] = cur_ff.peer_port;
                           lp_in[cur_ff.slot[SW-1:0]] = cur_ff.own_port;
                           mac_in[cur_ff.slot[SW-1:0]] = '0;
                           seq_in[cur_ff.slot[SW-1:0]] = cur_ff.start_seq;
                           ack_in[cur_ff.slot[SW-1:0]] = '0;
                           mk_in[cur_ff.slot[SW-1:0]] = 4'b0001;
                           len_in[cur_ff.slot[SW-1:0]] = '0;
                           r.conn_status = ST_SYN_SENT; r.ok = 1'b1;
                        end else begin
                           r.conn_status = st_ff[cur_ff.slot[SW-1:0]];
                           if (st_ff[cur_ff.slot[SW-1:0]] == ST_EST) begin
                              if (cur_ff.op == OP_CLOSE) begin
                                 mk_in[cur_ff.slot[SW-1:0]][3] = 1'b1; r.ok = 1'b1;
                              end else if (int'(cur_ff.byte_count) <= MAX_SEND) begin
                                 mk_in[cur_ff.slot[SW-1:0]][2] = 1'b1;
                                 len_in[cur_ff.slot[SW-1:0]] = cur_ff.byte_count[9:0];
                                 r.ok = 1'b1;
                              end
                           end
                        end
                     end
                  end
                  OP_ARP: begin
                     if (found_ff) begin
                        mac_in[hs] = cur_ff.peer_mac; mk_in[hs][1] = 1'b1;
                        r.out_slot = 3'(hs); r.conn_status = st_ff[hs]; r.ok = 1'b1;
                     end
                  end
                  OP_SEGMENT: begin
                     if (found_ff) begin
                        r = '0; r.out_slot = 3'(hs); r.ok = 1'b1; r.last = 1'b1;
                        r.tx_seq = seq_ff[hs]; r.dest_mac = mac_ff[hs];
                        r.dest_ip = ip_ff[hs]; r.ip_ident = id_ff;
                        r.conn_status = st_ff[hs];
                        emit = 1'b0;
                        case (st_ff[hs])
                           ST_SYN_SENT: begin
                              if (cur_ff.seg_flags[F_SYN] && cur_ff.seg_flags[F_ACK]) begin
                                 ack_in[hs] = cur_ff.seg_seq + 32'd1; st_in[hs] = ST_EST;
                                 r.action = ACT_ACK; r.conn_status = ST_EST; emit = 1'b1;
                              end
                           end
                           ST_EST: begin
                              if (!seg2_ff && cur_ff.byte_count != 11'd0) begin
                                 ack_in[hs] = sum + {31'd0, cur_ff.seg_flags[F_SYN]}
                                            + {31'd0, cur_ff.seg_flags[F_FIN]};
                                 r.action = ACT_ACK; r.tx_ack = ack_in[hs]; emit = 1'b1;
                                 if (cur_ff.seg_flags[F_FIN]) begin
                                    r.last = 1'b0; seg2_in = 1'b1; fsm_in = S_EXEC;
                                 end
                              end else if (cur_ff.seg_flags[F_FIN]) begin
                                 ack_in[hs] = sum + 32'd1; st_in[hs] = ST_CW;
                                 r.action = ACT_ACK; r.conn_status = ST_CW; emit = 1'b1;
                              end
                           end
                           ST_FW1, ST_FW2: begin
                              if (cur_ff.seg_flags[F_FIN]) begin
                                 ack_in[hs] = sum + 32'd1; st_in[hs] = ST_TW;
                                 r.action = ACT_ACK; r.conn_status = ST_TW; emit = 1'b1;
                              end else if (st_ff[hs] == ST_FW1 && cur_ff.seg_flags[F_ACK])
                                 st_in[hs] = ST_FW2;
                           end
                           ST_TW: st_in[hs] = ST_CLOSED;
                           default: ;
                        endcase
                        if (emit) begin
                           r.tx_ack = ack_in[hs]; id_in = id_ff + 16'd1;
                        end else begin
                           r = none_rsp(3'(hs), st_in[hs], 1'b1); r.last = 1'b1;
                           emit = 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
      endcase

      if (emit) begin
         rv_in = 1'b1; rd_in = r;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in; hit_ff <= hit_in; rd_ff <= rd_in;
      if (reset) begin
         for (int k = 0; k < SLOTS; k++) begin
            st_ff[k] <= ST_CLOSED; lp_ff[k] <= '0; rp_ff[k] <= '0; ip_ff[k] <= '0;
            mac_ff[k] <= '0; seq_ff[k] <= '0; ack_ff[k] <= '0; mk_ff[k] <= '0;
            len_ff[k] <= '0;
         end
         id_ff <= 16'd1; fsm_ff <= S_IDLE; idx_ff <= '0; found_ff <= 1'b0;
         nout_ff <= '0; seg2_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         for (int k = 0; k < SLOTS; k++) begin
            st_ff[k] <= st_in[k]; lp_ff[k] <= lp_in[k]; rp_ff[k] <= rp_in[k];
            ip_ff[k] <= ip_in[k]; mac_ff[k] <= mac_in[k]; seq_ff[k] <= seq_in[k];
            ack_ff[k] <= ack_in[k]; mk_ff[k] <= mk_in[k]; len_ff[k] <= len_in[k];
         end
         id_ff <= id_in; fsm_ff <= fsm_in; idx_ff <= idx_in; found_ff <= found_in;
         nout_ff <= nout_in; seg2_ff <= seg2_in; rv_ff <= rv_in;
      end
   end
endmodule

>>> sv/tce_checker.sv
// Port-level checks of the connection engine, bound to the top level.
`include "tcp_client_connection_engine_defines.svh"
module tce_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tce_pkg::rsp_type rsp_data
);
   import tce_pkg::*;
   logic out_held, arp_out, none_out, none_clear, poll_out;

   assign out_held   = rsp_valid && !rsp_ready;
   assign arp_out    = rsp_valid && rsp_data.action == ACT_ARP;
   assign none_out   = rsp_valid && rsp_data.action == ACT_NONE;
   assign none_clear = rsp_data.tx_len == 10'd0 && rsp_data.ip_ident == 16'd0;
   assign poll_out   = rsp_valid && rsp_data.action != ACT_NONE &&
                       rsp_data.action != ACT_ACK;

   `TCE_ASSERT_NEXT(a_hold, clock, reset, out_held, rsp_valid && $stable(rsp_data))
   `TCE_ASSERT_IMPL(a_arp_bcast, clock, reset, arp_out, rsp_data.dest_mac == MAC_ALL)
   `TCE_ASSERT_IMPL(a_none_zero, clock, reset, none_out, none_clear)
   `TCE_ASSERT_IMPL(a_poll_ok, clock, reset, poll_out, !rsp_data.ok)
endmodule

bind tcp_client_connection_engine tce_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

>>> sim/tce_tb_pkg.sv
// Expected-result computation for the TCP client connection engine testbench.
package tce_tb_pkg;
   import tce_pkg::*;

   localparam int N_SLOTS  = 8;
   localparam int SEND_MAX = 512;

   localparam logic [3:0] MK_ARP  = 4'b0001;
   localparam logic [3:0] MK_SYN  = 4'b0010;
   localparam logic [3:0] MK_DATA = 4'b0100;
   localparam logic [3:0] MK_FIN  = 4'b1000;

   typedef struct {
      logic [2:0]  state [N_SLOTS];
      logic [15:0] lport [N_SLOTS];
      logic [15:0] rport [N_SLOTS];
      logic [31:0] rip [N_SLOTS];
      logic [47:0] rmac [N_SLOTS];
      logic [31:0] snd [N_SLOTS];
      logic [31:0] ackn [N_SLOTS];
      logic [3:0]  marks [N_SLOTS];
      logic [9:0]  plen [N_SLOTS];
      logic [15:0] ident;
   } conn_table_type;

   function automatic void table_clear(ref conn_table_type t);
      for (int i = 0; i < N_SLOTS; i++) begin
         t.state[i] = ST_CLOSED; t.lport[i] = '0; t.rport[i] = '0; t.rip[i] = '0;
         t.rmac[i] = '0; t.snd[i] = '0; t.ackn[i] = '0; t.marks[i] = '0;
         t.plen[i] = '0;
      end
      t.ident = 16'd1;
   endfunction

   function automatic rsp_type idle_rsp(input logic [2:0] sl, input logic [2:0] st,
                                        input logic okv);
      rsp_type r;
      r = '0;
      r.out_slot = sl;
      r.conn_status = st;
      r.ok = okv;
      return r;
   endfunction

   // Build a TCP transmit order for slot i and advance the IP identification.
   function automatic rsp_type tcp_order(ref conn_table_type t, input int i,
                                         input logic [2:0] act, input logic [9:0] len,
                                         input logic okv);
      rsp_type r;
      r = '0;
      r.action = act; r.out_slot = 3'(i); r.tx_seq = t.snd[i]; r.tx_ack = t.ackn[i];
      r.tx_len = len; r.dest_mac = t.rmac[i]; r.dest_ip = t.rip[i];
      r.ip_ident = t.ident; r.conn_status = t.state[i]; r.ok = okv;
      t.ident = t.ident + 16'd1;
      return r;
   endfunction

   function automatic void segment_results(ref conn_table_type t, input req_type q,
                                           ref rsp_type res[$]);
      int i;
      logic [31:0] pay;
      i = 0;
      pay = 32'(q.byte_count);
      if (!q.sum_ok) begin
         res.push_back(idle_rsp(3'd0, ST_CLOSED, 1'b0));
         return;
      end
      while (i < N_SLOTS && !(t.lport[i] == q.own_port && t.rport[i] == q.peer_port &&
                              t.rip[i] == q.peer_ip))
         i++;
      if (i >= N_SLOTS) begin
         res.push_back(idle_rsp(3'd0, ST_CLOSED, 1'b0));
         return;
      end
      case (t.state[i])
         ST_SYN_SENT: if (q.seg_flags[F_SYN] && q.seg_flags[F_ACK]) begin
            t.ackn[i] = q.seg_seq + 32'd1;
            t.state[i] = ST_EST;
            res.push_back(tcp_order(t, i, ACT_ACK, '0, 1'b1));
         end
         ST_EST: begin
            if (pay != 0) begin
               t.ackn[i] = q.seg_seq + pay + 32'(q.seg_flags[F_SYN]) +
                           32'(q.seg_flags[F_FIN]);
               res.push_back(tcp_order(t, i, ACT_ACK, '0, 1'b1));
            end
            if (q.seg_flags[F_FIN]) begin
               t.ackn[i] = q.seg_seq + pay + 32'd1;
               t.state[i] = ST_CW;
               res.push_back(tcp_order(t, i, ACT_ACK, '0, 1'b1));
            end
         end
         ST_FW1, ST_FW2: begin
            if (q.seg_flags[F_FIN]) begin
               t.ackn[i] = q.seg_seq + pay + 32'd1;
               t.state[i] = ST_TW;
               res.push_back(tcp_order(t, i, ACT_ACK, '0, 1'b1));
            end else if (t.state[i] == ST_FW1 && q.seg_flags[F_ACK]) begin
               t.state[i] = ST_FW2;
            end
         end
         ST_TW: t.state[i] = ST_CLOSED;
         default: ;
      endcase
      if (res.size() == 0) res.push_back(idle_rsp(3'(i), t.state[i], 1'b1));
   endfunction

   function automatic void poll_results(ref conn_table_type t, ref rsp_type res[$]);
      rsp_type r;
      logic est;
      for (int i = 0; i < N_SLOTS && res.size() < RES_MAX; i++) begin
         est = (t.state[i] == ST_EST);
         if (t.marks[i] & MK_ARP) begin
            r = '0;
            r.action = ACT_ARP; r.out_slot = 3'(i); r.dest_mac = MAC_ALL;
            r.dest_ip = t.rip[i]; r.conn_status = t.state[i];
            res.push_back(r);
            t.marks[i] &= ~MK_ARP;
         end else if (t.marks[i] & MK_SYN) begin
            res.push_back(tcp_order(t, i, ACT_SYN, '0, 1'b0));
            t.snd[i] += 32'd1;
            t.marks[i] &= ~MK_SYN;
         end else if ((t.marks[i] & MK_DATA) && est) begin
            res.push_back(tcp_order(t, i, ACT_DATA, t.plen[i], 1'b0));
            t.snd[i] += 32'(t.plen[i]);
            t.plen[i] = '0;
            t.marks[i] &= ~MK_DATA;
         end else if ((t.marks[i] & MK_FIN) && est) begin
            t.state[i] = ST_FW1;
            res.push_back(tcp_order(t, i, ACT_FIN, '0, 1'b0));
            t.snd[i] += 32'd1;
            t.marks[i] &= ~MK_FIN;
         end
      end
      if (res.size() == 0) res.push_back(idle_rsp(3'd0, ST_CLOSED, 1'b0));
   endfunction

   // Apply one request to the table and return every result it causes.
   function automatic void predict_engine(ref conn_table_type t, input req_type q,
                                          ref rsp_type res[$]);
      int s;
      s = q.slot;
      res.delete();
      case (q.op)
         OP_CONNECT: begin
            t.state[s] = ST_SYN_SENT; t.rip[s] = q.peer_ip; t.rport[s] = q.peer_port;
            t.lport[s] = q.own_port; t.rmac[s] = '0; t.snd[s] = q.start_seq;
            t.ackn[s] = '0; t.marks[s] = MK_ARP; t.plen[s] = '0;
            res.push_back(idle_rsp(q.slot, ST_SYN_SENT, 1'b1));
         end
         OP_ARP: begin
            int i;
            i = 0;
            while (i < N_SLOTS && !(t.state[i] == ST_SYN_SENT && t.rip[i] == q.peer_ip))
               i++;
            if (i < N_SLOTS) begin
               t.rmac[i] = q.peer_mac;
               t.marks[i] |= MK_SYN;
               res.push_back(idle_rsp(3'(i), t.state[i], 1'b1));
            end else res.push_back(idle_rsp(3'd0, ST_CLOSED, 1'b0));
         end
         OP_SEGMENT: segment_results(t, q, res);
         OP_SEND: begin
            if (t.state[s] == ST_EST && q.byte_count <= SEND_MAX) begin
               t.plen[s] = 10'(q.byte_count);
               t.marks[s] |= MK_DATA;
               res.push_back(idle_rsp(q.slot, t.state[s], 1'b1));
            end else res.push_back(idle_rsp(q.slot, t.state[s], 1'b0));
         end
         OP_CLOSE: begin
            if (t.state[s] == ST_EST) begin
               t.marks[s] |= MK_FIN;
               res.push_back(idle_rsp(q.slot, t.state[s], 1'b1));
            end else res.push_back(idle_rsp(q.slot, t.state[s], 1'b0));
         end
         OP_POLL: poll_results(t, res);
         default: res.push_back(idle_rsp(3'd0, ST_CLOSED, 1'b0));
      endcase
      res[res.size() - 1].last = 1'b1;
   endfunction
endpackage

>>> sim/tb_top.sv
// Top-level testbench: directed and random connection traffic, checked result by result.
module tb_top;
   import tce_pkg::*;
   import tce_tb_pkg::*;

   logic clock;
   logic reset;

   tce_if #(.payload_type(req_type)) req_ch (clock);
   tce_if #(.payload_type(rsp_type)) rsp_ch (clock);

   tcp_client_connection_engine u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   conn_table_type conn_model;
   rsp_type     pending_rsp[$];
   int          error_count;
   bit          calm;        // suppress random idling on both sides
   int          hold_cycles; // receiver hold-off, counted down by its own process

   // Keep one peer per slot so random segments and ARP replies hit real slots.
   logic [31:0] peer_ips[N_SLOTS];
   logic [15:0] peer_ports[N_SLOTS];
   logic [15:0] own_ports[N_SLOTS];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit: far beyond the slowest correct run.
   initial begin
      #(12 * 600000);
      $display("tcp_client_connection_engine test failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   // Receiver: stall at random, hold off when asked, check every transaction.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            rsp_type got, want;
            got = rsp_ch.data;
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected result", 64'(got.action), 64'hx);
            end else begin
               want = pending_rsp.pop_front();
               if (got.action !== want.action)
                  report_mismatch("action", got.action, want.action);
               if (got.out_slot !== want.out_slot)
                  report_mismatch("out_slot", got.out_slot, want.out_slot);
               if (got.tx_seq !== want.tx_seq) report_mismatch("tx_seq", got.tx_seq, want.tx_seq);
               if (got.tx_ack !== want.tx_ack) report_mismatch("tx_ack", got.tx_ack, want.tx_ack);
               if (got.tx_len !== want.tx_len) report_mismatch("tx_len", got.tx_len, want.tx_len);
               if (got.dest_mac !== want.dest_mac)
                  report_mismatch("dest_mac", got.dest_mac, want.dest_mac);
               if (got.dest_ip !== want.dest_ip)
                  report_mismatch("dest_ip", got.dest_ip, want.dest_ip);
               if (got.ip_ident !== want.ip_ident)
                  report_mismatch("ip_ident", got.ip_ident, want.ip_ident);
               if (got.conn_status !== want.conn_status)
                  report_mismatch("conn_status", got.conn_status, want.conn_status);
               if (got.ok !== want.ok) report_mismatch("ok", got.ok, want.ok);
               if (got.last !== want.last) report_mismatch("last", got.last, want.last);
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
         end
      end
   end

   // Offer one transaction, idling at random first; predict on acceptance.
   // Valid stays high after acceptance until the next call idles or offers again.
   task automatic send_request(input req_type q);
      rsp_type res[$];
      if (!calm) begin
         while ($urandom_range(99) < 13) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= q;
      do @(posedge clock); while (!req_ch.ready);
      predict_engine(conn_model, q, res);
      foreach (res[k]) pending_rsp.push_back(res[k]);
   endtask

   function automatic req_type blank_req(input logic [2:0] op);
      req_type q;
      q = '0;
      q.op = op;
      q.sum_ok = 1'b1;
      return q;
   endfunction

   function automatic req_type segment_for(input int s, input logic [8:0] flags,
                                           input logic [10:0] len);
      req_type q;
      q = blank_req(OP_SEGMENT);
      q.peer_ip = peer_ips[s]; q.peer_port = peer_ports[s]; q.own_port = own_ports[s];
      q.seg_flags = flags; q.seg_seq = $urandom; q.byte_count = len;
      return q;
   endfunction

   function automatic req_type connect_for(input int s);
      req_type q;
      q = blank_req(OP_CONNECT);
      q.slot = 3'(s); q.peer_ip = peer_ips[s]; q.peer_port = peer_ports[s];
      q.own_port = own_ports[s]; q.start_seq = $urandom;
      return q;
   endfunction

   function automatic req_type arp_for(input int s);
      req_type q;
      q = blank_req(OP_ARP);
      q.peer_ip = peer_ips[s];
      q.peer_mac = 48'({$urandom, $urandom});
      return q;
   endfunction

   // Bring slot s up: connect, ARP, two polls, SYN+ACK.
   task automatic open_slot(input int s);
      send_request(connect_for(s));
      send_request(arp_for(s));
      send_request(blank_req(OP_POLL));
      send_request(blank_req(OP_POLL));
      send_request(segment_for(s, 9'h012, 11'd0));
   endtask

   // Directed: field extremes, every op, each special case.
   task automatic test_directed;
      req_type q;
      for (int s = 0; s < N_SLOTS; s++) begin
         peer_ips[s] = (s == 7) ? 32'hFFFF_FFFF : $urandom;
         peer_ports[s] = (s == 7) ? 16'hFFFF : 16'($urandom);
         own_ports[s] = (s == 7) ? 16'hFFFF : 16'($urandom);
      end
      send_request(blank_req(OP_POLL));              // nothing pending
      send_request(blank_req(OP_RSVD));              // unknown operation
      send_request(blank_req(OP_DROP));
      q = segment_for(0, 9'h1FF, 11'd0); q.sum_ok = 1'b0;
      send_request(q);                               // checksum drop
      q = blank_req(OP_SEGMENT); q.byte_count = 11'd1500;
      send_request(q);                               // zero tuple matches a closed slot
      send_request(arp_for(3));                      // ARP with no waiting slot
      open_slot(7);
      q = blank_req(OP_SEND); q.slot = 3'd7; q.byte_count = 11'd513;
      send_request(q);                               // too long
      q.byte_count = 11'd512; send_request(q);
      q.slot = 3'd0; send_request(q);                // not established
      q = blank_req(OP_CLOSE); q.slot = 3'd7; send_request(q);
      send_request(blank_req(OP_POLL));              // data goes out
      send_request(blank_req(OP_POLL));              // then the FIN
      send_request(segment_for(7, 9'h010, 11'd0));   // ACK of our FIN, wait for theirs
      send_request(segment_for(7, 9'h011, 11'd1500)); // FIN with payload
      send_request(segment_for(7, 9'h000, 11'd0));   // end the final wait, slot closes
   endtask

   // Random: mostly well-formed life cycles per slot with noise mixed in.
   task automatic test_random(input int count);
      req_type q;
      logic [223:0] noise;
      int s, pick;
      for (int n = 0; n < count; n++) begin
         s = $urandom_range(N_SLOTS - 1);
         pick = $urandom_range(99);
         if (pick < 8) q = connect_for(s);
         else if (pick < 16) q = arp_for(s);
         else if (pick < 30) q = blank_req(OP_POLL);
         else if (pick < 52) begin
            q = segment_for(s, 9'($urandom), 11'($urandom_range(3) == 0 ?
                            $urandom_range(1500) : $urandom_range(4)));
            if ($urandom_range(3) == 0) q.seg_flags = 9'h012;
            if ($urandom_range(15) == 0) q.sum_ok = 1'b0;
         end else if (pick < 70) begin
            q = blank_req(OP_SEND); q.slot = 3'(s);
            q.byte_count = 11'($urandom_range(15) == 0 ? $urandom_range(2047)
                                                      : $urandom_range(512));
         end else if (pick < 80) begin
            q = blank_req(OP_CLOSE); q.slot = 3'(s);
         end else begin
            // noise: every field random, including unknown operations
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            q = noise[$bits(req_type)-1:0];
            if (q.byte_count > 11'd1500) q.byte_count = 11'd1500;
            if ($urandom_range(3) == 0) begin
               q.peer_ip = peer_ips[s]; q.peer_port = peer_ports[s];
               q.own_port = own_ports[s];
            end
         end
         send_request(q);
      end
   endtask

   // Fill every slot with pending work, then stall the receiver for a long stretch.
   task automatic test_backpressure;
      calm = 1'b1;
      for (int s = 0; s < N_SLOTS; s++) send_request(connect_for(s));
      hold_cycles = 300;
      for (int k = 0; k < 6; k++) send_request(blank_req(OP_POLL));
      for (int s = 0; s < N_SLOTS; s++) send_request(arp_for(s));
      send_request(blank_req(OP_POLL));
      calm = 1'b0;
   endtask

   initial begin
      int guard;
      error_count = 0;
      calm = 1'b0;
      hold_cycles = 0;
      table_clear(conn_model);
      reset = 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(150);
      test_backpressure();
      calm = 1'b1;          // no idling for this stretch
      test_random(80);
      calm = 1'b0;
      test_random(160);
      req_ch.valid <= 1'b0;
      guard = 0;
      while (pending_rsp.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("tcp_client_connection_engine test passed");
      end else begin
         $display("tcp_client_connection_engine test failed");
      end
      $finish;
   end
endmodule

>>> tcp_client_connection_engine.f
+incdir+sv
sv/tce_pkg.sv
sv/tce_if.sv
sv/tce_queue.sv
sv/tce_front.sv
sv/tce_back.sv
sv/tcp_client_connection_engine.sv
sv/tce_checker.sv
sim/tce_tb_pkg.sv
sim/tb_top.sv
